### rtl/gcpl_pkg.sv
package gcpl_pkg;

    // Decoder phase: what the next stream byte means
    typedef enum logic [4:0] {
        PH_COUNT  = 5'b00001,
        PH_FIRST  = 5'b00010,
        PH_GAP    = 5'b00100,
        PH_EXT_LO = 5'b01000,
        PH_EXT_HI = 5'b10000
    } phase_t;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned HIDX_W  = 2;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h00;

endpackage

### rtl/gap_coded_prime_list_decoder.sv
// Gap-coded list decoder. Takes one stream byte per item on s_axis and emits
// decoded 32-bit values on m_axis, with tlast on the final value of each list.
// Every list opens with a 4-byte little-endian count; a nonzero count is
// followed by a 4-byte little-endian first value, then one gap byte per value
// (a zero byte escapes to a 16-bit little-endian gap in the next two bytes).
// Sums wrap modulo 2^32 and a zero count emits nothing. Each byte is decoded
// in the cycle it is accepted and any result lands in a single output
// register, so the block takes one byte every clock cycle; the output register
// is refilled in the same cycle it drains, so the input stalls only while a
// result waits with m_axis_tready low. A result appears in the cycle after the
// byte that causes it. A truncated stream is not flagged: later bytes simply
// continue the list.
module gap_coded_prime_list_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // Input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    // Decoded values
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] prime_value
    output logic        m_axis_tlast    // last_prime
);
    import gcpl_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [HIDX_W-1:0]   hdr_idx_reg, hdr_idx_next;
    logic [WORD_W-1:0]   hdr_shift_reg, hdr_shift_next;
    logic [WORD_W-1:0]   left_reg, left_next;
    logic [WORD_W-1:0]   cur_reg, cur_next;
    logic [BYTE_W-1:0]   ext_low_reg, ext_low_next;

    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_value_reg, out_value_next;
    logic                out_last_reg, out_last_next;

    logic                accept;
    logic                hdr_done;
    logic [WORD_W-1:0]   hdr_word;
    logic [WORD_W-1:0]   left_dec;
    logic [WORD_W-1:0]   byte_ext;
    logic                emit;
    logic [WORD_W-1:0]   emit_value;

    // Take a new item whenever the output register is free or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign byte_ext = {{(WORD_W-BYTE_W){1'b0}}, s_axis_tdata};
    assign left_dec = left_reg - {{(WORD_W-1){1'b0}}, 1'b1};
    assign hdr_done = (hdr_idx_reg == {HIDX_W{1'b1}});

    // Merge the byte into the header word at its little-endian position
    always_comb
    begin
        case (hdr_idx_reg)
            2'd0:    hdr_word = byte_ext;
            2'd1:    hdr_word = hdr_shift_reg | (byte_ext << 8);
            2'd2:    hdr_word = hdr_shift_reg | (byte_ext << 16);
            default: hdr_word = hdr_shift_reg | (byte_ext << 24);
        endcase
    end

    // Decode one byte
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        hdr_shift_next = hdr_shift_reg;
        left_next      = left_reg;
        cur_next       = cur_reg;
        ext_low_next   = ext_low_reg;
        emit           = 1'b0;
        emit_value     = cur_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    hdr_shift_next = hdr_word;
                    hdr_idx_next   = hdr_idx_reg + 1'b1;
                    if (hdr_done)
                    begin
                        emit_value = hdr_word;
                        emit       = 1'b1;
                    end
                end
                PH_GAP:
                begin
                    if (s_axis_tdata == ESCAPE_BYTE)
                    begin
                        phase_next = PH_EXT_LO;
                    end
                    else
                    begin
                        emit_value = cur_reg + byte_ext;
                        emit       = 1'b1;
                    end
                end
                PH_EXT_LO:
                begin
                    ext_low_next = s_axis_tdata;
                    phase_next   = PH_EXT_HI;
                end
                PH_EXT_HI:
                begin
                    emit_value = cur_reg
                               + {{(WORD_W-2*BYTE_W){1'b0}}, s_axis_tdata, ext_low_reg};
                    emit       = 1'b1;
                end
                default:
                begin
                    // Count header; unused phase codes land here too
                    phase_next     = PH_COUNT;
                    hdr_shift_next = hdr_word;
                    hdr_idx_next   = hdr_idx_reg + 1'b1;
                    if (hdr_done)
                    begin
                        left_next = hdr_word;
                        if (hdr_word != '0)
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                end
            endcase

            // Advance the list count on every emitted value
            if (emit)
            begin
                cur_next   = emit_value;
                left_next  = left_dec;
                phase_next = (left_dec == '0) ? PH_COUNT : PH_GAP;
            end
        end
    end

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_value_next = emit_value;
            out_last_next  = (left_dec == '0);
        end
    end

    // Hold decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_COUNT;
            hdr_idx_reg   <= '0;
            hdr_shift_reg <= '0;
            left_reg      <= '0;
            cur_reg       <= '0;
            ext_low_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            hdr_shift_reg <= hdr_shift_next;
            left_reg      <= left_next;
            cur_reg       <= cur_next;
            ext_low_reg   <= ext_low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### tb/tb_gap_coded_prime_list_decoder.sv
`timescale 1ns / 100ps

module tb_gap_coded_prime_list_decoder;

    import gcpl_pkg::*;

    localparam int unsigned STREAM_TARGET = 950;
    localparam int unsigned QUIET_TAIL    = 120;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned MAX_REPORTS   = 40;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Pending stream bytes and the drain-hold flag for each
    logic [BYTE_W-1:0] stream_bytes[$];
    bit                hold_before[$];

    // Expected decoded values, oldest first
    decoded_t expected_values[$];
    decoded_t head_value;
    int unsigned results_due = 0;
    int unsigned results_seen;
    int unsigned fail_count = 0;
    int unsigned idle_cycles;
    int unsigned send_gap;
    int unsigned stall_left;
    bit          quiet_tail;

    // Decoder state mirrored for prediction
    phase_t            dec_phase = PH_COUNT;
    logic [HIDX_W-1:0] hdr_pos = '0;
    logic [WORD_W-1:0] hdr_word = '0;
    logic [WORD_W-1:0] values_left = '0;
    logic [WORD_W-1:0] run_value = '0;
    logic [BYTE_W-1:0] esc_low = '0;

    gap_coded_prime_list_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Gather one little-endian header byte; true once the fourth is in
    function automatic bit take_header(input logic [BYTE_W-1:0] b);
        logic [HIDX_W-1:0] pos;
        pos = hdr_pos;
        if (pos == '0)
            hdr_word = {24'd0, b};
        else
            hdr_word = hdr_word | ({24'd0, b} << (8 * pos));
        hdr_pos = pos + 1'b1;
        return pos == 2'd3;
    endfunction

    // Queue the running value and count it off the list
    task automatic emit_value();
        decoded_t item;
        values_left = values_left - 1;
        item.value = run_value;
        item.last  = (values_left == '0);
        expected_values.push_back(item);
        results_due++;
        dec_phase = item.last ? PH_COUNT : PH_GAP;
    endtask

    // Advance the predicted decoder by one accepted byte
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        case (dec_phase)
            PH_FIRST:
            begin
                if (take_header(b))
                begin
                    run_value = hdr_word;
                    emit_value();
                end
            end
            PH_GAP:
            begin
                if (b == ESCAPE_BYTE)
                    dec_phase = PH_EXT_LO;
                else
                begin
                    run_value = run_value + {24'd0, b};
                    emit_value();
                end
            end
            PH_EXT_LO:
            begin
                esc_low   = b;
                dec_phase = PH_EXT_HI;
            end
            PH_EXT_HI:
            begin
                run_value = run_value + {16'd0, b, esc_low};
                emit_value();
            end
            default:
            begin
                dec_phase = PH_COUNT;
                if (take_header(b))
                begin
                    values_left = hdr_word;
                    if (values_left != '0)
                        dec_phase = PH_FIRST;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // Stream building helpers
    task automatic push_byte(input logic [BYTE_W-1:0] b, input bit hold);
        stream_bytes.push_back(b);
        hold_before.push_back(hold);
    endtask

    task automatic push_word(input logic [WORD_W-1:0] w, input bit hold);
        push_byte(w[7:0], hold);
        push_byte(w[15:8], 1'b0);
        push_byte(w[23:16], 1'b0);
        push_byte(w[31:24], 1'b0);
    endtask

    task automatic push_escaped_gap(input logic [15:0] g);
        push_byte(ESCAPE_BYTE, 1'b0);
        push_byte(g[7:0], 1'b0);
        push_byte(g[15:8], 1'b0);
    endtask

    task automatic push_random_gap();
        if ($urandom_range(0, 3) != 0)
            push_byte(8'($urandom_range(1, 255)), 1'b0);
        else if ($urandom_range(0, 7) == 0)
            push_escaped_gap(16'h0000);
        else
            push_escaped_gap(16'($urandom()));
    endtask

    // Driver: present pending bytes, predict each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            send_gap      <= 0;
            quiet_tail    <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata);
                void'(stream_bytes.pop_front());
                void'(hold_before.pop_front());
            end
            quiet_tail <= (stream_bytes.size() < QUIET_TAIL);
            // hold a presented item until it is taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (stream_bytes.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (hold_before[0] && results_due != results_seen)
                    s_axis_tvalid <= 1'b0;
                else if (stream_bytes.size() >= QUIET_TAIL && $urandom_range(0, 11) == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= $urandom_range(0, 16);
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= stream_bytes[0];
                end
            end
        end
    end

    // Monitor: check each accepted value against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            results_seen  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_values.size() == 0)
                    report_mismatch("unexpected value", m_axis_tdata, 32'h0);
                else
                begin
                    head_value = expected_values.pop_front();
                    if (m_axis_tdata !== head_value.value)
                        report_mismatch("value", m_axis_tdata, head_value.value);
                    if (m_axis_tlast !== head_value.last)
                        report_mismatch("last flag", {31'd0, m_axis_tlast},
                                        {31'd0, head_value.last});
                end
            end
            // stall the output in random bursts, none started in the tail
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= $urandom_range(0, 16);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_gap_coded_prime_list_decoder failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned count;
        int unsigned list_no;

        // empty list
        push_word(32'h0000_0000, 1'b0);
        // single value list carries the last flag at once
        push_word(32'h0000_0001, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        // short and escaped gaps, zero escaped gap, wrap past 2^32
        push_word(32'h0000_0004, 1'b0);
        push_word(32'hFFFF_FF00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_escaped_gap(16'h0000);
        push_escaped_gap(16'hFFFF);

        // random lists, some held until every value so far has come out
        list_no = 0;
        while (stream_bytes.size() < STREAM_TARGET - 100)
        begin
            if ($urandom_range(0, 9) == 0)
                count = 0;
            else if ($urandom_range(0, 15) == 0)
                count = $urandom_range(20, 40);
            else
                count = $urandom_range(1, 10);
            push_word(count, list_no == 0 || $urandom_range(0, 19) == 0);
            if (count != 0)
            begin
                push_word($urandom(), 1'b0);
                for (int i = 1; i < count; i++)
                    push_random_gap();
            end
            list_no++;
        end

        // a list too long to finish: the stream just stops partway
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word($urandom(), 1'b0);
        for (int i = 0; i < 40; i++)
            push_random_gap();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (stream_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (results_due != results_seen)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_values.size() != 0)
            report_mismatch("values never seen", 32'h0, expected_values.size());
        if (fail_count == 0)
            $display("tb_gap_coded_prime_list_decoder passed");
        else
            $display("tb_gap_coded_prime_list_decoder failed");
        $finish;
    end

endmodule
